### rtl/apsp_pkg.sv
// Shared types and constants for the all-pairs shortest path engine.
package apsp_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Fixed field widths of the item and configuration channels
  localparam int CMD_W    = 2;
  localparam int VIDX_W   = 4;
  localparam int EDGE_W   = 16;
  localparam int DIST_W   = 32;
  localparam int VCOUNT_W = 5;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_INIT,
    ST_LOAD_IK,
    ST_RELAX,
    ST_SCAN,
    ST_SCAN_END,
    ST_READ,
    ST_FINISH
  } state_e;

  // One entry of the path memory
  typedef struct packed {
    logic                     reach;
    logic signed [DIST_W-1:0] distance;
  } path_t;

  // Outcome of one relaxation step
  typedef struct packed {
    logic                     upd;
    logic signed [DIST_W-1:0] distance;
  } relax_t;

endpackage

### rtl/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path engine: memories, sequencer and channels.
//
//  channel | handshake               | payload                                    | dir
//  --------+-------------------------+--------------------------------------------+----
//  cfg     | cfg_valid_i/cfg_ready_o | vertex_count_i                             | in
//  in      | in_valid_i/in_ready_o   | cmd_i src_vertex_i dst_vertex_i            | in
//          |                         | edge_weight_i                              |
//  out     | out_valid_o/out_ready_i | distance_o reachable_o negative_cycle_o    | out
//
// Edge writes go straight to the adjacency memory; a read returns one path entry; clear zeroes
//   all DEPTH = 2**(2*clog2(MAX_VERTICES)) adjacency entries (256 at 16 vertices); solve copies
//   them into the path memory, then relaxes every pair for each k, one relaxation per cycle
//   within a row, through the path memory, which has two read ports and one write port.
// Reset: the adjacency memory is zeroed by a sweep over all DEPTH entries; in_ready_o stays low
//   meanwhile. Configuration writes are taken at any time.
// Stalls: the output register holds a finished item while the next one is accepted; a new
//   result then waits in the sequencer until the output register frees up.
module all_pairs_shortest_path #(
  parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = apsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [apsp_pkg::VCOUNT_W-1:0] vertex_count_i,
  // command items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [apsp_pkg::CMD_W-1:0]    cmd_i,
  input  logic        [apsp_pkg::VIDX_W-1:0]   src_vertex_i,
  input  logic        [apsp_pkg::VIDX_W-1:0]   dst_vertex_i,
  input  logic signed [apsp_pkg::EDGE_W-1:0]   edge_weight_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [apsp_pkg::DIST_W-1:0]   distance_o,
  output logic                                 reachable_o,
  output logic                                 negative_cycle_o
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int PW    = 2 * VW;
  localparam int DEPTH = 1 << PW;

  localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

  apsp_pkg::state_e state_q, state_d;
  apsp_pkg::cmd_e   cmd;

  logic          in_fire;
  logic          in_range;
  logic [VW-1:0] src_idx, dst_idx;

  logic signed [32:0]            w_ext, w_sat;
  logic signed [WEIGHT_BITS-1:0] w_store;

  logic [apsp_pkg::VCOUNT_W-1:0] vertex_count_q;
  logic [VW-1:0]                 nl_act;

  // sequencer counters
  logic [PW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] k_q, k_d, i_q, i_d, j_q, j_d, nl_q, nl_d;

  // adjacency memory
  logic signed [WEIGHT_BITS-1:0] adj_mem [DEPTH];
  logic                          adj_we;
  logic [PW-1:0]                 adj_waddr;
  logic signed [WEIGHT_BITS-1:0] adj_wdata;
  logic signed [WEIGHT_BITS-1:0] adj_rdata_q;

  // path memory
  apsp_pkg::path_t path_mem [DEPTH];
  logic            path_we;
  logic [PW-1:0]   path_waddr;
  apsp_pkg::path_t path_wdata;
  logic [PW-1:0]   pa_addr, pb_addr;
  apsp_pkg::path_t pa_q, pb_q;

  // read-data stage
  logic            init_v_q, init_v_d, ikld_v_q, ikld_v_d;
  logic            rel_v_q, rel_v_d, scan_v_q, scan_v_d;
  logic [PW-1:0]   init_addr_q, s1_addr_q;
  logic            s1_jk_q;
  logic [VW-1:0]   init_i, init_j;
  apsp_pkg::path_t init_val;
  apsp_pkg::path_t ik_q, ik_d;
  apsp_pkg::relax_t relax_res;

  logic            cycle_flag_q, cycle_flag_d;
  logic            in_range_q, in_range_d;
  apsp_pkg::path_t res_q, res_d;
  logic            out_valid_q, out_valid_d, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cmd         = apsp_pkg::cmd_e'(cmd_i);
  assign src_idx     = VW'(src_vertex_i);
  assign dst_idx     = VW'(dst_vertex_i);
  assign in_range    = (int'(src_vertex_i) < MAX_VERTICES) && (int'(dst_vertex_i) < MAX_VERTICES);

  // Saturate the incoming weight to the stored width
  assign w_ext = 33'(edge_weight_i);
  always_comb begin
    if (w_ext > W_HI) begin
      w_sat = W_HI;
    end else if (w_ext < W_LO) begin
      w_sat = W_LO;
    end else begin
      w_sat = w_ext;
    end
    w_store = WEIGHT_BITS'(w_sat);
  end

  // Active vertex count, clamped to 1..MAX_VERTICES, kept as last index
  always_comb begin
    if (vertex_count_q == '0) begin
      nl_act = '0;
    end else if (int'(vertex_count_q) > MAX_VERTICES) begin
      nl_act = VW'(MAX_VERTICES - 1);
    end else begin
      nl_act = VW'(vertex_count_q - 5'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      apsp_pkg::ST_SWEEP: begin
        if (cnt_q == '1) state_d = apsp_pkg::ST_IDLE;
      end
      apsp_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            apsp_pkg::CMD_CLEAR: state_d = apsp_pkg::ST_SWEEP;
            apsp_pkg::CMD_SOLVE: state_d = apsp_pkg::ST_INIT;
            apsp_pkg::CMD_READ:  state_d = apsp_pkg::ST_READ;
            default:             state_d = apsp_pkg::ST_IDLE;
          endcase
        end
      end
      apsp_pkg::ST_INIT: begin
        if (cnt_q == '1) state_d = apsp_pkg::ST_LOAD_IK;
      end
      apsp_pkg::ST_LOAD_IK: state_d = apsp_pkg::ST_RELAX;
      apsp_pkg::ST_RELAX: begin
        if (j_q == nl_q) begin
          if (i_q == nl_q && k_q == nl_q) begin
            state_d = apsp_pkg::ST_SCAN;
          end else begin
            state_d = apsp_pkg::ST_LOAD_IK;
          end
        end
      end
      apsp_pkg::ST_SCAN: begin
        if (!rel_v_q && i_q == nl_q) state_d = apsp_pkg::ST_SCAN_END;
      end
      apsp_pkg::ST_SCAN_END: state_d = apsp_pkg::ST_FINISH;
      apsp_pkg::ST_READ:     state_d = apsp_pkg::ST_FINISH;
      apsp_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = apsp_pkg::ST_IDLE;
      end
      default: state_d = apsp_pkg::ST_SWEEP;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: handshake, memory ports, counters, issue flags
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    adj_we     = 1'b0;
    adj_waddr  = cnt_q;
    adj_wdata  = '0;
    pa_addr    = '0;
    cnt_d      = cnt_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    nl_d       = nl_q;
    init_v_d   = 1'b0;
    ikld_v_d   = 1'b0;
    rel_v_d    = 1'b0;
    scan_v_d   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      apsp_pkg::ST_SWEEP: begin
        // zero one adjacency entry per cycle
        adj_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      apsp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        pa_addr    = {src_idx, dst_idx};
        if (in_fire && cmd == apsp_pkg::CMD_EDGE && in_range) begin
          adj_we    = 1'b1;
          adj_waddr = {src_idx, dst_idx};
          adj_wdata = w_store;
        end
        if (in_fire && cmd == apsp_pkg::CMD_SOLVE) begin
          nl_d = nl_act;
          k_d  = '0;
          i_d  = '0;
          j_d  = '0;
        end
      end
      apsp_pkg::ST_INIT: begin
        // stream adjacency into the path memory, one pair per cycle
        init_v_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
      apsp_pkg::ST_LOAD_IK: begin
        pa_addr  = {i_q, k_q};
        ikld_v_d = 1'b1;
      end
      apsp_pkg::ST_RELAX: begin
        pa_addr = {k_q, j_q};
        rel_v_d = 1'b1;
        if (j_q == nl_q) begin
          j_d = '0;
          if (i_q == nl_q) begin
            i_d = '0;
            k_d = k_q + 1'b1;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      apsp_pkg::ST_SCAN: begin
        pa_addr = {i_q, i_q};
        // hold off until the last relaxation has been written back
        if (!rel_v_q) begin
          scan_v_d = 1'b1;
          i_d      = i_q + 1'b1;
        end
      end
      apsp_pkg::ST_FINISH: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign pb_addr = {i_q, j_q};

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata_q <= adj_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    pa_q <= path_mem[pa_addr];
    pb_q <= path_mem[pb_addr];
  end

  // ---------------------------------------------------------------------------
  // Read-data stage: start values, relaxation, diagonal scan
  // ---------------------------------------------------------------------------
  assign init_i = init_addr_q[PW-1:VW];
  assign init_j = init_addr_q[VW-1:0];

  // Start value: stored weight, else zero on the diagonal, else unreachable;
  // pairs outside the active vertices read as unreachable
  always_comb begin
    init_val = '0;
    if (init_i <= nl_q && init_j <= nl_q) begin
      if (adj_rdata_q != '0) begin
        init_val.reach    = 1'b1;
        init_val.distance = 32'(adj_rdata_q);
      end else if (init_i == init_j) begin
        init_val.reach = 1'b1;
      end
    end
  end

  apsp_relax u_relax (
    .ik_i  (ik_q),
    .kj_i  (pa_q),
    .ij_i  (pb_q),
    .res_o (relax_res)
  );

  always_comb begin
    path_we    = 1'b0;
    path_waddr = s1_addr_q;
    path_wdata = '0;
    if (init_v_q) begin
      path_we    = 1'b1;
      path_waddr = init_addr_q;
      path_wdata = init_val;
    end else if (rel_v_q && relax_res.upd) begin
      path_we             = 1'b1;
      path_wdata.reach    = 1'b1;
      path_wdata.distance = relax_res.distance;
    end
  end

  // The row operand d[i][k] lives in a register; keep it in step when the row
  // rewrites its own column k
  always_comb begin
    ik_d = ik_q;
    if (ikld_v_q) begin
      ik_d = pa_q;
    end else if (rel_v_q && relax_res.upd && s1_jk_q) begin
      ik_d.reach    = 1'b1;
      ik_d.distance = relax_res.distance;
    end
  end

  always_comb begin
    cycle_flag_d = cycle_flag_q;
    if (in_fire && cmd == apsp_pkg::CMD_SOLVE) begin
      cycle_flag_d = 1'b0;
    end else if (scan_v_q && pa_q.reach && pa_q.distance < 0) begin
      cycle_flag_d = 1'b1;
    end
  end

  always_comb begin
    res_d      = res_q;
    in_range_d = in_range_q;
    if (in_fire) in_range_d = in_range;
    if (in_fire && cmd == apsp_pkg::CMD_SOLVE) begin
      res_d = '0;
    end else if (state_q == apsp_pkg::ST_READ) begin
      res_d = in_range_q ? pa_q : '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= apsp_pkg::ST_SWEEP;
      cnt_q          <= '0;
      k_q            <= '0;
      i_q            <= '0;
      j_q            <= '0;
      nl_q           <= '0;
      init_v_q       <= 1'b0;
      ikld_v_q       <= 1'b0;
      rel_v_q        <= 1'b0;
      scan_v_q       <= 1'b0;
      vertex_count_q <= apsp_pkg::VCOUNT_RST;
      cycle_flag_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      i_q      <= i_d;
      j_q      <= j_d;
      nl_q     <= nl_d;
      init_v_q <= init_v_d;
      ikld_v_q <= ikld_v_d;
      rel_v_q  <= rel_v_d;
      scan_v_q <= scan_v_d;
      if (cfg_valid_i && cfg_ready_o) vertex_count_q <= vertex_count_i;
      cycle_flag_q <= cycle_flag_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_addr_q <= cnt_q;
    s1_addr_q   <= {i_q, j_q};
    s1_jk_q     <= (j_q == k_q);
    ik_q        <= ik_d;
    in_range_q  <= in_range_d;
    res_q       <= res_d;
    if (out_load) begin
      distance_o       <= res_q.distance;
      reachable_o      <= res_q.reach;
      negative_cycle_o <= cycle_flag_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/apsp_relax.sv
// Relaxation datapath: saturating path sum and compare against the stored distance.
module apsp_relax (
  input  apsp_pkg::path_t  ik_i,
  input  apsp_pkg::path_t  kj_i,
  input  apsp_pkg::path_t  ij_i,
  output apsp_pkg::relax_t res_o
);

  logic signed [apsp_pkg::DIST_W:0]   sum;
  logic signed [apsp_pkg::DIST_W-1:0] sat;

  assign sum = 33'(ik_i.distance) + 33'(kj_i.distance);

  // Clamp on signed overflow: the two top bits of the sum disagree
  always_comb begin
    if (sum[apsp_pkg::DIST_W] != sum[apsp_pkg::DIST_W-1]) begin
      sat = sum[apsp_pkg::DIST_W] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
    end else begin
      sat = sum[apsp_pkg::DIST_W-1:0];
    end
  end

  assign res_o.upd      = ik_i.reach & kj_i.reach & (~ij_i.reach | (sat < ij_i.distance));
  assign res_o.distance = sat;

endmodule

### rtl/apsp_checker.sv
// Port-level assertions for the all-pairs shortest path engine, bound to the top level.
module apsp_props (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic        [apsp_pkg::CMD_W-1:0]    cmd_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [apsp_pkg::DIST_W-1:0]   distance_o,
  input logic                                 reachable_o,
  input logic                                 negative_cycle_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(distance_o) && $stable(reachable_o)
       && $stable(negative_cycle_o)))
    else $error("result changed while stalled");

  // Clear starts a sweep that blocks items
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == apsp_pkg::CMD_CLEAR) |=> !in_ready_o)
    else $error("item taken during clear sweep");

  // An edge write leaves the block ready again in the next cycle
  a_edge_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == apsp_pkg::CMD_EDGE) |=> in_ready_o)
    else $error("edge write did not complete in one cycle");

  // Solve and read keep the block busy until their result is produced
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == apsp_pkg::CMD_SOLVE || cmd_i == apsp_pkg::CMD_READ))
      |=> !in_ready_o)
    else $error("item taken while a result is pending");

  // A new result appears exactly as the block frees up
  a_result_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result appeared without the block going idle");

endmodule

bind all_pairs_shortest_path apsp_props u_apsp_props (.*);

### sim/apsp_checker.sv
// Checker for the all-pairs shortest path engine: tracks the graph, predicts results and compares.
module apsp_checker
  import apsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [VCOUNT_W-1:0]      vertex_count_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [VIDX_W-1:0]        src_vertex_i,
  input  logic [VIDX_W-1:0]        dst_vertex_i,
  input  logic signed [EDGE_W-1:0] edge_weight_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DIST_W-1:0] distance_i,
  input  logic                     reachable_i,
  input  logic                     negative_cycle_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       neg_solves_o
);

  localparam int NV     = MAX_VERTICES_DEF;
  localparam int NPAIRS = NV * NV;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     reach;
    logic                     neg;
    logic                     from_solve;
  } path_result_t;

  logic signed [EDGE_W-1:0] weight_mem [NPAIRS];
  logic signed [DIST_W-1:0] dist_mem   [NPAIRS];
  logic                     reach_mem  [NPAIRS];
  logic                     neg_cycle;
  logic [VCOUNT_W-1:0]      vcount;
  path_result_t             results_due [$];
  int                       fails;
  int                       checked;
  int                       neg_solves;

  function automatic int active_vertices();
    if (vcount == 0) return 1;
    if (vcount > NV) return NV;
    return int'(vcount);
  endfunction

  function automatic logic signed [DIST_W-1:0] add_sat(input logic signed [DIST_W-1:0] a,
                                                       input logic signed [DIST_W-1:0] b);
    logic signed [DIST_W:0] s;
    s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
    if (s > DIST_MAX) return DIST_MAX;
    if (s < DIST_MIN) return DIST_MIN;
    return s[DIST_W-1:0];
  endfunction

  // Floyd-Warshall in place, k outermost; pairs outside the active set end unreachable.
  function automatic void solve_paths();
    int n;
    int p;
    int ik;
    int kj;
    int ij;
    logic signed [DIST_W-1:0] s;
    n = active_vertices();
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        p = i * NV + j;
        dist_mem[p]  = '0;
        reach_mem[p] = 1'b0;
        if (i < n && j < n) begin
          if (weight_mem[p] != 0) begin
            dist_mem[p]  = DIST_W'(weight_mem[p]);
            reach_mem[p] = 1'b1;
          end else if (i == j) begin
            reach_mem[p] = 1'b1;
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        ik = i * NV + k;
        for (int j = 0; j < n; j++) begin
          kj = k * NV + j;
          ij = i * NV + j;
          if (reach_mem[ik] && reach_mem[kj]) begin
            s = add_sat(dist_mem[ik], dist_mem[kj]);
            if (!reach_mem[ij] || s < dist_mem[ij]) begin
              dist_mem[ij]  = s;
              reach_mem[ij] = 1'b1;
            end
          end
        end
      end
    end
    neg_cycle = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (reach_mem[i * NV + i] && dist_mem[i * NV + i] < 0) neg_cycle = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    path_result_t want;
    int           p;
    if (!rst_ni) begin
      for (int k = 0; k < NPAIRS; k++) begin
        weight_mem[k] = '0;
        dist_mem[k]   = '0;
        reach_mem[k]  = 1'b0;
      end
      neg_cycle = 1'b0;
      vcount    = VCOUNT_RST;
      results_due.delete();
      fails      = 0;
      checked    = 0;
      neg_solves = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      neg_solves_o <= 0;
    end else begin
      // retire the oldest expectation before taking a new item
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result item with no expectation waiting");
          fails++;
        end else begin
          want = results_due.pop_front();
          checked++;
          if (want.from_solve && want.neg) neg_solves++;
          if (distance_i !== want.distance) begin
            $error("distance: expected %0d, got %0d", $signed(want.distance), distance_i);
            fails++;
          end
          if (reachable_i !== want.reach) begin
            $error("reachable: expected %0b, got %0b", want.reach, reachable_i);
            fails++;
          end
          if (negative_cycle_i !== want.neg) begin
            $error("negative_cycle: expected %0b, got %0b", want.neg, negative_cycle_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        p = int'(src_vertex_i) * NV + int'(dst_vertex_i);
        case (cmd_e'(cmd_i))
          CMD_CLEAR: begin
            for (int k = 0; k < NPAIRS; k++) weight_mem[k] = '0;
          end
          CMD_EDGE: begin
            weight_mem[p] = edge_weight_i;
          end
          CMD_SOLVE: begin
            solve_paths();
            want.distance   = '0;
            want.reach      = 1'b0;
            want.neg        = neg_cycle;
            want.from_solve = 1'b1;
            results_due.push_back(want);
          end
          default: begin
            want.distance   = reach_mem[p] ? dist_mem[p] : '0;
            want.reach      = reach_mem[p];
            want.neg        = neg_cycle;
            want.from_solve = 1'b0;
            results_due.push_back(want);
          end
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) vcount = vertex_count_i;
      fail_count_o <= fails;
      pending_o    <= results_due.size();
      checked_o    <= checked;
      neg_solves_o <= neg_solves;
    end
  end

endmodule

### sim/tb_all_pairs_shortest_path.sv
// Testbench top for the all-pairs shortest path engine: stimulus, back-pressure and verdict.
module tb_all_pairs_shortest_path;
  import apsp_pkg::*;

  // Longest legal quiet stretch is one full 16-vertex solve plus the longest receiver
  // stall and sender gap; allow several times that.
  localparam int STALL_LIMIT   = 40000;
  // Idle time after the last result before a register write or the verdict; covers a
  // clear sweep, which produces no result item.
  localparam int SETTLE_CYCLES = 320;
  localparam int RANDOM_ITEMS  = 120;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_valid      = 1'b0;
  logic                     cfg_ready;
  logic [VCOUNT_W-1:0]      vertex_count   = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd            = '0;
  logic [VIDX_W-1:0]        src_vertex     = '0;
  logic [VIDX_W-1:0]        dst_vertex     = '0;
  logic signed [EDGE_W-1:0] edge_weight    = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic signed [DIST_W-1:0] distance;
  logic                     reachable;
  logic                     negative_cycle;

  int fail_count;
  int results_pending;
  int results_checked;
  int neg_solves;

  int items_sent     = 0;
  int solves_sent    = 0;
  int reads_sent     = 0;
  int settings_used  = 0;
  int directed_items = 0;
  int quiet_cycles   = 0;
  int ready_hold     = 0;
  bit burst          = 1'b0;

  always #1 clk = ~clk;

  all_pairs_shortest_path i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .vertex_count_i   (vertex_count),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cmd),
    .src_vertex_i     (src_vertex),
    .dst_vertex_i     (dst_vertex),
    .edge_weight_i    (edge_weight),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .distance_o       (distance),
    .reachable_o      (reachable),
    .negative_cycle_o (negative_cycle)
  );

  apsp_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .vertex_count_i   (vertex_count),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .cmd_i            (cmd),
    .src_vertex_i     (src_vertex),
    .dst_vertex_i     (dst_vertex),
    .edge_weight_i    (edge_weight),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .distance_i       (distance),
    .reachable_i      (reachable),
    .negative_cycle_i (negative_cycle),
    .fail_count_o     (fail_count),
    .pending_o        (results_pending),
    .checked_o        (results_checked),
    .neg_solves_o     (neg_solves)
  );

  // Receiver back-pressure: hold ready at one level for a random stretch. Mostly long
  // ready runs and short stalls, now and then a long stall, so results pile up in the
  // output register while the sequencer finishes the next one.
  always @(posedge clk) begin
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 23);
      end else if (r < 93) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(20, 80);
      end
    end
  end

  // Watchdog: end the run when no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results still due",
               quiet_cycles, results_pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Drop valid and idle the sender for a number of cycles.
  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random gap after an accepted item: none in burst phases, else mostly short.
  // With no gap, valid stays high and the next item follows back to back.
  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return;
    if (r < 94) pause_sender($urandom_range(1, 3));
    else pause_sender($urandom_range(15, 60));
  endtask

  // Present one item and hold it until the block accepts it.
  task automatic send_item(input cmd_e op, input logic [VIDX_W-1:0] src,
                           input logic [VIDX_W-1:0] dst, input logic signed [EDGE_W-1:0] w);
    in_valid    <= 1'b1;
    cmd         <= op;
    src_vertex  <= src;
    dst_vertex  <= dst;
    edge_weight <= w;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == CMD_SOLVE) solves_sent++;
    if (op == CMD_READ) reads_sent++;
    sender_gap();
  endtask

  // Stop sending and wait until every expected result item has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Drain, then let a clear sweep that owes no result run out.
  task automatic settle();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [VCOUNT_W-1:0] value);
    in_valid     <= 1'b0;
    cfg_valid    <= 1'b1;
    vertex_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly inside the active set so solves see real paths, sometimes anywhere.
  function automatic logic [VIDX_W-1:0] pick_vertex(input int n);
    if ($urandom_range(0, 99) < 85) return VIDX_W'($urandom_range(0, n - 1));
    return VIDX_W'($urandom_range(0, 15));
  endfunction

  // Mostly small weights so paths chain; a few negatives make cycles now and then.
  function automatic logic signed [EDGE_W-1:0] pick_weight();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) v = $urandom_range(1, 20);
    else if (r < 55) v = -int'($urandom_range(1, 5));
    else if (r < 65) v = 0;
    else if (r < 75) v = $urandom_range(0, 1) ? 32767 : -32768;
    else v = $urandom_range(0, 65535);
    return v[EDGE_W-1:0];
  endfunction

  initial begin
    int                  phase;
    int                  n;
    logic [VCOUNT_W-1:0] v;

    // hold reset, release on a clock edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on four active vertices: overwrite of an edge, a stored self-loop,
    // an edge outside the active set, full-scale weights, a negative cycle, clear that
    // keeps solved paths and the cycle flag, and a zero weight that removes an edge.
    set_vertex_count(5'd4);
    send_item(CMD_CLEAR, 4'd0, 4'd0, 16'sd0);
    send_item(CMD_EDGE, 4'd0, 4'd1, 16'sh7fff);
    send_item(CMD_EDGE, 4'd1, 4'd2, 16'sh8000);
    send_item(CMD_EDGE, 4'd2, 4'd3, 16'sd5);
    send_item(CMD_EDGE, 4'd0, 4'd1, 16'sd7);
    send_item(CMD_EDGE, 4'd3, 4'd3, 16'sd3);
    send_item(CMD_EDGE, 4'd15, 4'd15, -16'sd1);
    send_item(CMD_SOLVE, 4'd0, 4'd0, 16'sd0);
    send_item(CMD_READ, 4'd0, 4'd3, 16'sd0);
    send_item(CMD_READ, 4'd3, 4'd0, 16'sd0);
    send_item(CMD_READ, 4'd3, 4'd3, 16'sd0);
    send_item(CMD_READ, 4'd15, 4'd15, 16'sd0);
    send_item(CMD_READ, 4'd0, 4'd0, 16'sd0);
    send_item(CMD_EDGE, 4'd2, 4'd1, 16'sd1);
    send_item(CMD_SOLVE, 4'd0, 4'd0, 16'sd0);
    send_item(CMD_READ, 4'd1, 4'd1, 16'sd0);
    send_item(CMD_CLEAR, 4'd0, 4'd0, 16'sd0);
    send_item(CMD_READ, 4'd1, 4'd2, 16'sd0);
    send_item(CMD_SOLVE, 4'd0, 4'd0, 16'sd0);
    send_item(CMD_EDGE, 4'd0, 4'd1, 16'sd0);
    send_item(CMD_READ, 4'd0, 4'd1, 16'sd0);
    directed_items = items_sent;

    // Random phases: each one a register write on an idle block, then a well-formed
    // build-solve-read sequence with random content and a little noise at the end.
    // The first phases take the extreme counts; later ones stay mostly small to keep
    // solves short, with the odd full-size one.
    phase = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      case (phase)
        0:       v = 5'd0;
        1:       v = 5'd31;
        2:       v = 5'd17;
        3:       v = 5'd1;
        4:       v = 5'd16;
        default: v = ($urandom_range(0, 4) == 0) ? VCOUNT_W'($urandom_range(0, 31))
                                                 : VCOUNT_W'($urandom_range(2, 6));
      endcase
      settle();
      set_vertex_count(v);
      n = (v == 0) ? 1 : (v > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(v);
      burst = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 1)) send_item(CMD_CLEAR, VIDX_W'($urandom_range(0, 15)),
                                          VIDX_W'($urandom_range(0, 15)), pick_weight());
      repeat ($urandom_range(1, (n < 6) ? 2 * n + 1 : 12)) begin
        send_item(CMD_EDGE, pick_vertex(n), pick_vertex(n), pick_weight());
      end
      send_item(CMD_SOLVE, VIDX_W'($urandom_range(0, 15)), VIDX_W'($urandom_range(0, 15)),
                pick_weight());
      // sometimes hold the sender until the solve result is back
      if ($urandom_range(0, 2) == 0) wait_results_drained();
      repeat ($urandom_range(2, 6)) begin
        send_item(CMD_READ, pick_vertex(n), pick_vertex(n), pick_weight());
      end
      // noise: any command with any field values
      repeat ($urandom_range(0, 2)) begin
        send_item(cmd_e'(CMD_W'($urandom_range(0, 3))), VIDX_W'($urandom_range(0, 15)),
                  VIDX_W'($urandom_range(0, 15)), EDGE_W'($urandom_range(0, 65535)));
      end
      phase++;
    end

    settle();
    $display("Covered %0d items (%0d solves, %0d reads) over %0d vertex-count writes",
             items_sent, solves_sent, reads_sent, settings_used);
    $display("Compared %0d result items; %0d solves reported a negative cycle",
             results_checked, neg_solves);
    if (fail_count == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/apsp_pkg.sv
rtl/apsp_relax.sv
rtl/all_pairs_shortest_path.sv
rtl/apsp_checker.sv
sim/apsp_checker.sv
sim/tb_all_pairs_shortest_path.sv
